FILE: hdl/sawp_pkg.sv
// shared constants, types and functions for the pivot walk core
`timescale 1ns / 1ps
`default_nettype none
package sawp_pkg;
    localparam int MaxPoints = 1024;
    localparam int Dim = 2;
    localparam int AW = $clog2(MaxPoints);
    localparam int LW = 11;
    localparam int CW = 16;
    localparam int PW = 3 * CW;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PIVOT = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_CHECK = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_COLL = 3'd1;
    localparam logic [2:0] ST_IDENT = 3'd2;
    localparam logic [2:0] ST_OVF = 3'd3;
    localparam logic [2:0] ST_BADIDX = 3'd4;

    typedef logic [PW-1:0] point_t;

    // source coordinate for output coordinate k
    function automatic logic [1:0] perm_src(input logic [2:0] psel, input int k);
        logic [1:0] r;
        r = 2'(k);
        if (Dim == 3) begin
            case (psel)
                3'd1: r = (k == 0) ? 2'd0 : (k == 1) ? 2'd2 : 2'd1;
                3'd2: r = (k == 0) ? 2'd1 : (k == 1) ? 2'd0 : 2'd2;
                3'd3: r = (k == 0) ? 2'd1 : (k == 1) ? 2'd2 : 2'd0;
                3'd4: r = (k == 0) ? 2'd2 : (k == 1) ? 2'd0 : 2'd1;
                3'd5: r = (k == 0) ? 2'd2 : (k == 1) ? 2'd1 : 2'd0;
                default: r = 2'(k);
            endcase
        end else begin
            if (psel == 3'd1 && k < 2)
                r = (k == 0) ? 2'd1 : 2'd0;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/self_avoiding_walk_pivot_core.sv
// pivot move engine for a lattice self-avoiding walk
// Channels: start/busy command input with one result strobed by done for one
// cycle; cfg_valid/cfg_ready writes walk_length (ready while idle).
// A load result shows in the cycle after the item is taken; a read result
// passes through S_READ first. A check compares every pair of points through
// the single store read port. A pivot at index p with tail t reads p+1
// points per tail point, then copies the proposal buffer back into the
// store; a collision or an overflow ends it early.
// busy stays high from start until the done cycle; the next item can be
// taken the cycle after done.
// Reset sets walk_length to 1024 and returns the control to idle; the point
// memories are not cleared and hold undefined data until loaded.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module self_avoiding_walk_pivot_core
    import sawp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [9:0]         point_index,
    input  wire logic signed [15:0] coord_x,
    input  wire logic signed [15:0] coord_y,
    input  wire logic signed [15:0] coord_z,
    input  wire logic [2:0]         perm_select,
    input  wire logic [2:0]         sign_mask,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [10:0]        cfg_data,
    output logic                    done,
    output logic [2:0]              status,
    output logic                    is_self_avoiding,
    output logic signed [15:0]      out_x,
    output logic signed [15:0]      out_y,
    output logic signed [15:0]      out_z
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_PIVP  = 8'b0000_0100,
        S_PIVQ  = 8'b0000_1000,
        S_PIVJ  = 8'b0001_0000,
        S_COPY  = 8'b0010_0000,
        S_CHKI  = 8'b0100_0000,
        S_CHKJ  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [LW-1:0] len_reg;
    logic [AW-1:0] piv_reg, piv_next, i_reg, i_next, j_reg, j_next;
    logic [2:0] psel_reg, psel_next, smask_reg, smask_next;
    point_t p_reg, p_next, a_reg, a_next, q_reg, q_next;
    logic wait_reg, wait_next;
    logic [LW-1:0] n;
    logic done_next;
    logic [2:0] status_next;
    logic avoid_next;
    point_t rd_out_next;

    logic st_we, pb_we;
    logic [AW-1:0] st_wa, st_ra, pb_wa, pb_ra;
    point_t st_wd, st_rd, pb_wd, pb_rd, mapped;
    logic map_ovf;

    sawp_ram u_store (.clk, .we(st_we), .waddr(st_wa), .wdata(st_wd),
        .raddr(st_ra), .rdata(st_rd));
    sawp_ram u_prop (.clk, .we(pb_we), .waddr(pb_wa), .wdata(pb_wd),
        .raddr(pb_ra), .rdata(pb_rd));
    sawp_map u_map (.q(st_rd), .p(p_reg), .psel(psel_reg), .smask(smask_reg),
        .r(mapped), .ovf(map_ovf));

    assign n = (len_reg > LW'(MaxPoints)) ? LW'(MaxPoints) : len_reg;
    assign busy = (state_reg != S_IDLE) || done;
    assign cfg_ready = !busy;

    function automatic logic ident_xf(input logic [2:0] ps, input logic [2:0] sm);
        logic id;
        id = 1'b1;
        for (int k = 0; k < Dim; k++)
            if (perm_src(ps, k) != 2'(k) || sm[k])
                id = 1'b0;
        return id;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        piv_next = piv_reg; i_next = i_reg; j_next = j_reg;
        psel_next = psel_reg; smask_next = smask_reg;
        p_next = p_reg; a_next = a_reg; q_next = q_reg;
        wait_next = 1'b0;
        done_next = 1'b0; status_next = ST_OK; avoid_next = 1'b0;
        rd_out_next = '0;
        st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
        pb_we = 1'b0; pb_wa = '0; pb_wd = '0; pb_ra = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    piv_next = point_index; psel_next = perm_select;
                    smask_next = sign_mask;
                    st_ra = point_index;
                    case (req_type)
                        REQ_LOAD:
                        begin
                            done_next = 1'b1;
                            if (LW'(point_index) < n)
                            begin
                                st_we = 1'b1; st_wa = point_index;
                                st_wd = {(Dim == 3) ? coord_z : 16'sd0, coord_y, coord_x};
                            end
                            else
                                status_next = ST_BADIDX;
                        end
                        REQ_READ:
                        begin
                            if (LW'(point_index) < n)
                                state_next = S_READ;
                            else
                            begin
                                done_next = 1'b1; status_next = ST_BADIDX;
                            end
                        end
                        REQ_PIVOT:
                        begin
                            if (ident_xf(perm_select, sign_mask))
                            begin
                                done_next = 1'b1; status_next = ST_IDENT;
                            end
                            else if (LW'(point_index) >= n)
                            begin
                                done_next = 1'b1; status_next = ST_BADIDX;
                            end
                            else
                                state_next = S_PIVP;
                        end
                        default:
                        begin
                            if (n < LW'(2))
                            begin
                                done_next = 1'b1; avoid_next = 1'b1;
                            end
                            else
                            begin
                                i_next = '0; st_ra = '0; state_next = S_CHKI;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next = 1'b1; rd_out_next = st_rd; state_next = S_IDLE;
            end
            S_PIVP:
            begin
                // st_rd holds pivot point
                p_next = st_rd;
                if (LW'(piv_reg) + LW'(1) >= n)
                begin
                    done_next = 1'b1; state_next = S_IDLE;
                end
                else
                begin
                    i_next = piv_reg + AW'(1);
                    st_ra = piv_reg + AW'(1);
                    state_next = S_PIVQ;
                end
            end
            S_PIVQ:
            begin
                // st_rd holds tail point i
                q_next = mapped;
                if (map_ovf)
                begin
                    done_next = 1'b1; status_next = ST_OVF; state_next = S_IDLE;
                end
                else
                begin
                    j_next = '0; st_ra = '0; state_next = S_PIVJ;
                end
            end
            S_PIVJ:
            begin
                // st_rd holds point j
                if (st_rd == q_reg)
                begin
                    done_next = 1'b1; status_next = ST_COLL; state_next = S_IDLE;
                end
                else if (j_reg != piv_reg)
                begin
                    j_next = j_reg + AW'(1); st_ra = j_reg + AW'(1);
                end
                else
                begin
                    pb_we = 1'b1; pb_wa = i_reg; pb_wd = q_reg;
                    if (LW'(i_reg) + LW'(1) >= n)
                    begin
                        i_next = piv_reg + AW'(1);
                        wait_next = 1'b1;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        i_next = i_reg + AW'(1); st_ra = i_reg + AW'(1);
                        state_next = S_PIVQ;
                    end
                end
            end
            S_COPY:
            begin
                // pb read issued for i_reg; data valid in the next cycle
                pb_ra = i_reg;
                if (wait_reg)
                begin
                    wait_next = 1'b0; j_next = i_reg; i_next = i_reg + AW'(1);
                end
                else
                begin
                    st_we = 1'b1; st_wa = j_reg; st_wd = pb_rd;
                    if (LW'(j_reg) + LW'(1) >= n)
                    begin
                        done_next = 1'b1; state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next = j_reg + AW'(1);
                        i_next = i_reg + AW'(1);
                    end
                end
            end
            S_CHKI:
            begin
                // st_rd holds point i
                a_next = st_rd;
                j_next = i_reg + AW'(1); st_ra = i_reg + AW'(1);
                state_next = S_CHKJ;
            end
            S_CHKJ:
            begin
                if (st_rd == a_reg)
                begin
                    done_next = 1'b1; avoid_next = 1'b0; state_next = S_IDLE;
                end
                else if (LW'(j_reg) + LW'(1) < n)
                begin
                    j_next = j_reg + AW'(1); st_ra = j_reg + AW'(1);
                end
                else if (LW'(i_reg) + LW'(2) < n)
                begin
                    i_next = i_reg + AW'(1); st_ra = i_reg + AW'(1);
                    state_next = S_CHKI;
                end
                else
                begin
                    done_next = 1'b1; avoid_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= LW'(1024);
            done <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= done_next;
            wait_reg <= wait_next;
            if (cfg_valid && cfg_ready)
                len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        piv_reg <= piv_next; i_reg <= i_next; j_reg <= j_next;
        psel_reg <= psel_next; smask_reg <= smask_next;
        p_reg <= p_next; a_reg <= a_next; q_reg <= q_next;
        status <= status_next;
        is_self_avoiding <= avoid_next;
        out_x <= rd_out_next[CW-1:0];
        out_y <= rd_out_next[2*CW-1:CW];
        out_z <= rd_out_next[3*CW-1:2*CW];
    end
endmodule
`default_nettype wire

FILE: hdl/sawp_ram.sv
// single-port-write, one-read synchronous point memory
`timescale 1ns / 1ps
`default_nettype none
module sawp_ram
    import sawp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire point_t        wdata,
    input  wire logic [AW-1:0] raddr,
    output point_t             rdata
);
    point_t mem [MaxPoints];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/sawp_map.sv
// maps one tail point through p + T(q - p) with overflow flag
`timescale 1ns / 1ps
`default_nettype none
module sawp_map
    import sawp_pkg::*;
(
    input  wire point_t     q,
    input  wire point_t     p,
    input  wire logic [2:0] psel,
    input  wire logic [2:0] smask,
    output point_t          r,
    output logic            ovf
);
    logic signed [CW+2:0] d [3];
    logic signed [CW+2:0] v [3];
    always_comb
    begin
        ovf = 1'b0;
        r = '0;
        for (int k = 0; k < 3; k++)
            d[k] = (CW+3)'($signed(q[k*CW +: CW])) - (CW+3)'($signed(p[k*CW +: CW]));
        for (int k = 0; k < 3; k++) begin
            v[k] = '0;
            if (k < Dim) begin
                v[k] = d[perm_src(psel, k)];
                if (smask[k])
                    v[k] = -v[k];
                v[k] = v[k] + (CW+3)'($signed(p[k*CW +: CW]));
            end
            if (v[k] < -(CW+3)'(32768) || v[k] > (CW+3)'(32767))
                ovf = 1'b1;
            r[k*CW +: CW] = v[k][CW-1:0];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/sawp_checker.sv
// port-level assertions for the pivot walk core
`timescale 1ns / 1ps
`default_nettype none
module sawp_checker
    import sawp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       cfg_ready,
    input wire logic [2:0] status,
    input wire logic       is_self_avoiding
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted item not busy");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("cfg ready while busy");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_BADIDX) else $error("bad status");
    a_avoid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_self_avoiding |-> status == ST_OK) else $error("avoid flag");
endmodule

bind self_avoiding_walk_pivot_core sawp_checker u_sawp_checker (
    .clk, .rst_n, .start, .busy, .done, .cfg_ready, .status, .is_self_avoiding
);
`default_nettype wire
